### rtl/core/quoted_token_splitter_assert.svh
`ifndef QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_ASSERT_SVH

// check a property outside reset
`define QTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define QTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/qts_pkg.sv
package qts_pkg;

  localparam logic [2:0] KIND_BYTE      = 3'd0;
  localparam logic [2:0] KIND_TOKEN_END = 3'd1;
  localparam logic [2:0] KIND_EQUALS    = 3'd2;
  localparam logic [2:0] KIND_ACCEPT    = 3'd3;
  localparam logic [2:0] KIND_REJECT    = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CLOSE     = 3'd1;
  localparam logic [2:0] ERR_OPEN      = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd3;
  localparam logic [2:0] ERR_BACKSLASH = 3'd4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_EQUALS    = 8'h3D;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       last;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] data,
                                  input logic [2:0] err);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    r.last = 1'b0;
    mk_res = r;
  endfunction

endpackage

### rtl/core/quoted_token_splitter.sv
// channel | dir | tdata                  | tuser     | tlast
// in_     | in  | [7:0] in_byte          | -         | end_of_line
// out_    | out | [7:0] out_byte,        | [2:0] kind| last
//         |     | [10:8] error_code      |           |
//
// One input beat per cycle while in_tready is high; each beat is decoded in the cycle it is taken and
// pushes zero, one or two result beats into a four-entry result queue.
// in_tready drops while the queue holds more than two beats: when results back
// up behind a stalled output, or when two-result beats arrive back to back.
// Results leave one per cycle while out_tready is high; each result is registered in the queue first.
// Reset (rst_n low, synchronous) empties the queue and clears the line state.
`include "quoted_token_splitter_assert.svh"

module quoted_token_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last
);
  import qts_pkg::*;

  logic              in_quote_r, in_quote_nxt;
  logic              esc_r, esc_nxt;
  logic              close_chk_r, close_chk_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic              line_start_r, line_start_nxt;
  logic              tok_open_r, tok_open_nxt;
  logic              failed_r, failed_nxt;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  res_t              res0, res1, r0, r1;
  logic [1:0]        push_n, n;
  logic              in_acc, out_acc;
  logic [7:0]        c;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign c       = in_tdata;

  always_comb begin
    in_quote_nxt   = in_quote_r;
    esc_nxt        = esc_r;
    close_chk_nxt  = close_chk_r;
    prev_nxt       = prev_r;
    line_start_nxt = line_start_r;
    tok_open_nxt   = tok_open_r;
    failed_nxt     = failed_r;
    r0             = mk_res(KIND_BYTE, 8'd0, ERR_NONE);
    r1             = mk_res(KIND_BYTE, 8'd0, ERR_NONE);
    n              = 2'd0;
    if (in_tlast) begin
      if (!failed_r) begin
        if (in_quote_r) begin
          r0 = mk_res(KIND_REJECT, 8'd0, ERR_UNCLOSED);
          n  = 2'd1;
        end else if (esc_r) begin
          r0 = mk_res(KIND_REJECT, 8'd0, ERR_BACKSLASH);
          n  = 2'd1;
        end else if (tok_open_r) begin
          r0 = mk_res(KIND_TOKEN_END, 8'd0, ERR_NONE);
          r1 = mk_res(KIND_ACCEPT, 8'd0, ERR_NONE);
          n  = 2'd2;
        end else begin
          r0 = mk_res(KIND_ACCEPT, 8'd0, ERR_NONE);
          n  = 2'd1;
        end
      end
      in_quote_nxt   = 1'b0;
      esc_nxt        = 1'b0;
      close_chk_nxt  = 1'b0;
      prev_nxt       = 8'd0;
      line_start_nxt = 1'b1;
      tok_open_nxt   = 1'b0;
      failed_nxt     = 1'b0;
    end else if (!failed_r) begin
      if (close_chk_r && !is_ws(c)) begin
        r0         = mk_res(KIND_REJECT, 8'd0, ERR_CLOSE);
        n          = 2'd1;
        failed_nxt = 1'b1;
      end else begin
        close_chk_nxt = 1'b0;
        if (esc_r) begin
          r0           = mk_res(KIND_BYTE, c, ERR_NONE);
          n            = 2'd1;
          tok_open_nxt = 1'b1;
          esc_nxt      = 1'b0;
        end else if (c == CH_BACKSLASH) begin
          esc_nxt = 1'b1;
        end else if (c == CH_QUOTE) begin
          if (in_quote_r) begin
            in_quote_nxt  = 1'b0;
            close_chk_nxt = 1'b1;
          end else if (!line_start_r && !is_ws(prev_r) && (prev_r != CH_EQUALS)) begin
            r0         = mk_res(KIND_REJECT, 8'd0, ERR_OPEN);
            n          = 2'd1;
            failed_nxt = 1'b1;
          end else begin
            in_quote_nxt = 1'b1;
          end
        end else if (in_quote_r) begin
          r0           = mk_res(KIND_BYTE, c, ERR_NONE);
          n            = 2'd1;
          tok_open_nxt = 1'b1;
        end else if (c == CH_EQUALS) begin
          tok_open_nxt = 1'b0;
          if (tok_open_r) begin
            r0 = mk_res(KIND_TOKEN_END, 8'd0, ERR_NONE);
            r1 = mk_res(KIND_EQUALS, 8'd0, ERR_NONE);
            n  = 2'd2;
          end else begin
            r0 = mk_res(KIND_EQUALS, 8'd0, ERR_NONE);
            n  = 2'd1;
          end
        end else if (is_ws(c)) begin
          tok_open_nxt = 1'b0;
          if (tok_open_r) begin
            r0 = mk_res(KIND_TOKEN_END, 8'd0, ERR_NONE);
            n  = 2'd1;
          end
        end else begin
          r0           = mk_res(KIND_BYTE, c, ERR_NONE);
          n            = 2'd1;
          tok_open_nxt = 1'b1;
        end
        prev_nxt       = c;
        line_start_nxt = 1'b0;
      end
    end
    res0 = r0;
    res1 = r1;
    if (n == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  assign push_n = in_acc ? n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r   <= 1'b0;
      esc_r        <= 1'b0;
      close_chk_r  <= 1'b0;
      prev_r       <= 8'd0;
      line_start_r <= 1'b1;
      tok_open_r   <= 1'b0;
      failed_r     <= 1'b0;
    end else if (in_acc) begin
      in_quote_r   <= in_quote_nxt;
      esc_r        <= esc_nxt;
      close_chk_r  <= close_chk_nxt;
      prev_r       <= prev_nxt;
      line_start_r <= line_start_nxt;
      tok_open_r   <= tok_open_nxt;
      failed_r     <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(out_acc);
      cnt_r    <= cnt_r + QCNT_W'(push_n) - QCNT_W'(out_acc);
    end
  end

  assign in_tready  = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {5'd0, q_r[rd_ptr_r].err, q_r[rd_ptr_r].data};
  assign out_tuser  = q_r[rd_ptr_r].kind;
  assign out_tlast  = q_r[rd_ptr_r].last;

  `QTS_ASSERT_ALWAYS(a_cnt_bound, (!rst_n || (cnt_r <= QCNT_W'(QDEPTH))), "result queue overflow")
  `QTS_ASSERT(a_eol_clears, (in_acc && in_tlast) |=> (line_start_r && !failed_r && !in_quote_r && !tok_open_r), "line state not cleared at end of line")
  `QTS_ASSERT(a_failed_silent, (in_acc && failed_r && !in_tlast) |-> (push_n == 2'd0), "results after line rejection")
  `QTS_ASSERT(a_pair_last, (push_n == 2'd2) |-> (!res0.last && res1.last), "last misplaced on two-result beat")

endmodule

### tb/sv/quoted_token_splitter_test.sv
`timescale 1ns / 100ps

module quoted_token_splitter_test;
  import qts_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BEATS   = 500;

  typedef struct packed {
    logic [7:0] c;
    logic       eol;
  } line_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  line_beat_t line_stream[$];
  res_t       expected_tokens[$];
  int         queued_beats = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;

  logic       quoted = 1'b0;
  logic       escaped = 1'b0;
  logic       close_pending = 1'b0;
  logic [7:0] prev_byte = 8'd0;
  logic       line_start = 1'b1;
  logic       token_open = 1'b0;
  logic       line_failed = 1'b0;

  int         burst_left = 1;
  int         gap_left = 0;
  line_beat_t next_beat;
  int         stall_mode = 0;
  int         stall_left = 0;
  int         stall_tick = 0;
  logic       rx_ready;
  res_t       want;

  quoted_token_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void emit(input logic [2:0] kind, input logic [7:0] data,
                               input logic [2:0] err);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    r.last = 1'b0;
    expected_tokens.insert(expected_tokens.size(), r);
  endfunction

  function automatic void emit_byte(input logic [7:0] c);
    emit(KIND_BYTE, c, ERR_NONE);
    token_open = 1'b1;
  endfunction

  function automatic void close_token();
    if (token_open) begin
      emit(KIND_TOKEN_END, 8'd0, ERR_NONE);
      token_open = 1'b0;
    end
  endfunction

  function automatic void split_beat(input logic [7:0] c, input logic eol);
    int first;
    first = expected_tokens.size();
    if (eol) begin
      if (!line_failed) begin
        if (quoted) begin
          emit(KIND_REJECT, 8'd0, ERR_UNCLOSED);
        end else if (escaped) begin
          emit(KIND_REJECT, 8'd0, ERR_BACKSLASH);
        end else begin
          close_token();
          emit(KIND_ACCEPT, 8'd0, ERR_NONE);
        end
      end
      quoted        = 1'b0;
      escaped       = 1'b0;
      close_pending = 1'b0;
      prev_byte     = 8'd0;
      line_start    = 1'b1;
      token_open    = 1'b0;
      line_failed   = 1'b0;
    end else if (!line_failed) begin
      if (close_pending && !blank(c)) begin
        emit(KIND_REJECT, 8'd0, ERR_CLOSE);
        line_failed = 1'b1;
      end else begin
        close_pending = 1'b0;
        if (escaped) begin
          emit_byte(c);
          escaped = 1'b0;
        end else if (c == CH_BACKSLASH) begin
          escaped = 1'b1;
        end else if (c == CH_QUOTE) begin
          if (quoted) begin
            quoted        = 1'b0;
            close_pending = 1'b1;
          end else if (!line_start && !blank(prev_byte) && prev_byte != CH_EQUALS) begin
            emit(KIND_REJECT, 8'd0, ERR_OPEN);
            line_failed = 1'b1;
          end else begin
            quoted = 1'b1;
          end
        end else if (quoted) begin
          emit_byte(c);
        end else if (c == CH_EQUALS) begin
          close_token();
          emit(KIND_EQUALS, 8'd0, ERR_NONE);
        end else if (blank(c)) begin
          close_token();
        end else begin
          emit_byte(c);
        end
        prev_byte  = c;
        line_start = 1'b0;
      end
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  task automatic add(input logic [7:0] c, input logic eol = 1'b0);
    line_beat_t b;
    b.c   = c;
    b.eol = eol;
    line_stream.insert(line_stream.size(), b);
    queued_beats++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endtask

  task automatic end_line();
    add(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (blank(c) || c == CH_QUOTE || c == CH_BACKSLASH || c == CH_EQUALS);
    return c;
  endfunction

  function automatic logic [7:0] space_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(9, 13));
    return 8'd32;
  endfunction

  task automatic add_word_line();
    int words;
    int len;
    words = $urandom_range(0, 5);
    for (int w = 0; w < words; w++) begin
      if (w > 0 || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: add(space_char());
          1: add(CH_EQUALS);
          2: begin add(space_char()); add(CH_EQUALS); add(space_char()); end
          default: begin add(space_char()); add(space_char()); end
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        add(CH_QUOTE);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 4))
            0: add(space_char());
            1: add(CH_EQUALS);
            2: begin add(CH_BACKSLASH); add(8'($urandom_range(0, 255))); end
            default: add(plain_char());
          endcase
        end
        add(CH_QUOTE);
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            add(CH_BACKSLASH);
            add(8'($urandom_range(0, 255)));
          end else begin
            add(plain_char());
          end
        end
      end
    end
    if ($urandom_range(0, 3) == 0) add(space_char());
    end_line();
  endtask

  task automatic add_noise_line();
    int len;
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: add(CH_QUOTE);
        1: add(CH_BACKSLASH);
        2: add(CH_EQUALS);
        3: add(space_char());
        4: add(plain_char());
        default: add(8'($urandom_range(0, 255)));
      endcase
    end
    end_line();
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) split_beat(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (line_stream.size() > 0) begin
          next_beat = line_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_beat.c;
          in_tlast  <= next_beat.eol;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches at random between four modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: rx_ready = 1'b1;
        1: rx_ready = 1'($urandom_range(0, 1));
        2: rx_ready = ($urandom_range(0, 3) == 0);
        default: rx_ready = (stall_tick % 5) < 2;
      endcase
      out_tready <= rx_ready;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected beat kind %0d tdata %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata[7:0] !== want.data) begin
          $display("%0t: byte expected %h actual %h", $time, want.data, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[10:8] !== want.err) begin
          $display("%0t: error code expected %0d actual %0d",
                   $time, want.err, out_tdata[10:8]);
          mismatches++;
        end
        if (out_tdata[15:11] !== 5'd0) begin
          $display("%0t: tdata pad expected 0 actual %h", $time, out_tdata[15:11]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_text("a=b");
    end_line();
    add_text("\"a\"b");
    end_line();
    add_text("a\"");
    end_line();
    add_text("\"");
    end_line();
    add_text("\\");
    end_line();
    add(8'h00);
    add(8'hFF);
    add(8'h09);
    end_line();
    add_text("\"\"");
    end_line();

    // hold the random lines back until the directed lines have fully drained
    do @(negedge clk);
    while (line_stream.size() > 0 || in_tvalid || expected_tokens.size() > 0);

    queued_beats = 0;
    while (queued_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 7) add_word_line();
      else add_noise_line();
    end

    do @(negedge clk);
    while (line_stream.size() > 0 || in_tvalid || expected_tokens.size() > 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/qts_pkg.sv
rtl/core/quoted_token_splitter.sv
tb/sv/quoted_token_splitter_test.sv
